[design/upd_pkg.sv]
// Shared types, character codes and hex-digit helper for the URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none
package upd_pkg;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SPACE   = 8'h20;  // ' '
   localparam logic [7:0] CHAR_PERCENT = 8'h25;  // '%'
   localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;  // 'F'
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef enum logic [1:0] {
      PH_PLAIN = 2'd0,
      PH_ESC1  = 2'd1,
      PH_ESC2  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic       digit_ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       bad_escape;
   } result_type;

   // Only '0'-'9' and upper-case 'A'-'F' count as hex digits.
   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type    h;
      logic [7:0] diff;
      h    = '{digit_ok: 1'b0, value: 4'd0};
      diff = 8'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         diff     = b - CHAR_ZERO;
         h.digit_ok = 1'b1;
         h.value    = diff[3:0];
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         diff     = b - CHAR_UPPER_A + 8'd10;
         h.digit_ok = 1'b1;
         h.value    = diff[3:0];
      end
      return h;
   endfunction

endpackage
`default_nettype wire

[design/upd_core.sv]
// Decoder state machine: escape phase, pending high nibble, error flag.
`timescale 1ns / 1ps
`default_nettype none
module upd_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 fire,
   input  wire [7:0]           in_byte,
   input  wire                 in_last,
   output logic                emit,
   output upd_pkg::result_type result
);

   upd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         high_nibble_ff, high_nibble_in;
   logic               error_seen_ff, error_seen_in;

   upd_pkg::phase_type step_phase;
   logic [3:0]         step_nibble;
   logic               step_error;
   logic               have;
   logic [7:0]         ch;
   upd_pkg::hex_type   hex;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= upd_pkg::PH_PLAIN;
         high_nibble_ff <= 4'd0;
         error_seen_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         high_nibble_ff <= high_nibble_in;
         error_seen_ff  <= error_seen_in;
      end
   end

   always_comb begin
      hex         = upd_pkg::hex_decode(in_byte);
      step_phase  = phase_ff;
      step_nibble = high_nibble_ff;
      step_error  = error_seen_ff;
      have        = 1'b0;
      ch          = upd_pkg::CHAR_NUL;

      unique case (phase_ff)
         upd_pkg::PH_PLAIN: begin
            priority if (in_byte == upd_pkg::CHAR_PLUS) begin
               ch   = upd_pkg::CHAR_SPACE;
               have = 1'b1;
            end else if (in_byte == upd_pkg::CHAR_PERCENT) begin
               step_phase = upd_pkg::PH_ESC1;
            end else if (in_byte == upd_pkg::CHAR_NUL) begin
               step_phase = upd_pkg::PH_STOP;
            end else begin
               ch   = in_byte;
               have = 1'b1;
            end
         end
         upd_pkg::PH_ESC1: begin
            if (!hex.digit_ok) begin
               step_error = 1'b1;
               step_phase = upd_pkg::PH_STOP;
            end else begin
               step_nibble = hex.value;
               step_phase  = upd_pkg::PH_ESC2;
            end
         end
         upd_pkg::PH_ESC2: begin
            if (!hex.digit_ok) begin
               step_error = 1'b1;
               step_phase = upd_pkg::PH_STOP;
            end else if ({high_nibble_ff, hex.value} == upd_pkg::CHAR_NUL) begin
               step_phase = upd_pkg::PH_STOP;
            end else begin
               ch         = {high_nibble_ff, hex.value};
               have       = 1'b1;
               step_phase = upd_pkg::PH_PLAIN;
            end
         end
         upd_pkg::PH_STOP: begin
            // stopped: drop bytes until the end of the string
         end
         default: begin
         end
      endcase

      if (in_last) begin
         // an escape left open at the end counts as malformed
         emit              = 1'b1;
         result.out_byte   = ch;
         result.out_valid  = have;
         result.out_last   = 1'b1;
         result.bad_escape = step_error ||
                             step_phase == upd_pkg::PH_ESC1 ||
                             step_phase == upd_pkg::PH_ESC2;
         phase_in          = upd_pkg::PH_PLAIN;
         high_nibble_in    = 4'd0;
         error_seen_in     = 1'b0;
      end else begin
         emit              = have;
         result.out_byte   = ch;
         result.out_valid  = 1'b1;
         result.out_last   = 1'b0;
         result.bad_escape = 1'b0;
         phase_in          = step_phase;
         high_nibble_in    = step_nibble;
         error_seen_in     = step_error;
      end
   end

endmodule
`default_nettype wire

[design/upd_out_reg.sv]
// Result register between the decoder and the response channel.
`timescale 1ns / 1ps
`default_nettype none
module upd_out_reg (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 load,
   input  upd_pkg::result_type result,
   output logic                can_take,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output upd_pkg::result_type held
);

   logic                valid_ff, valid_in;
   upd_pkg::result_type data_ff;

   // a held result leaves this cycle or the register is empty
   assign can_take  = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign held      = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule
`default_nettype wire

[design/url_percent_decoder.sv]
// Top level of the streaming URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none
// Streaming URL percent decoder. Feed the encoded string one byte per request
// with req_in_last marking its final byte. A '+' becomes a space, '%' plus two
// hex digits ('0'-'9', upper-case 'A'-'F' only) becomes one byte, and every
// other byte passes through. A raw zero or %00 ends the output without error;
// a malformed or truncated escape ends it with rsp_bad_escape set on the final
// response. Once stopped, further bytes are dropped until the last one. Each
// request yields zero or one response: a decoded non-zero character, or, on
// the last byte, always exactly one response with rsp_out_last high
// (rsp_out_valid tells whether it carries a character). Throughput is one
// request per clock: the decode is a single pass of logic from the request
// ports and the escape state into one result register, so a response appears
// in the cycle after its request is accepted. req_ready drops only while that
// result register holds a response the consumer is not taking; requests that
// produce no response still wait on it. There are no configuration registers.
module url_percent_decoder (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_in_byte,
   input  wire        req_in_last,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic       rsp_bad_escape
);

   logic                fire;
   logic                emit;
   logic                can_take;
   upd_pkg::result_type result;
   upd_pkg::result_type held;

   // accept a request whenever the result register can take its response
   assign req_ready = can_take;
   assign fire      = req_valid && can_take;

   // advance the escape state and form this request's response, if any
   upd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .emit    (emit),
      .result  (result)
   );

   // hold the response until the consumer takes it
   upd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .result    (result),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .held      (held)
   );

   assign rsp_out_byte   = held.out_byte;
   assign rsp_out_valid  = held.out_valid;
   assign rsp_out_last   = held.out_last;
   assign rsp_bad_escape = held.bad_escape;

endmodule
`default_nettype wire

[design/upd_checker.sv]
// Port-level checks for the URL percent decoder and their binding.
`timescale 1ns / 1ps
`default_nettype none
module upd_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_out_byte,
   input wire       rsp_out_valid,
   input wire       rsp_out_last,
   input wire       rsp_bad_escape
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_out_valid) && $stable(rsp_out_last) && $stable(rsp_bad_escape))
      else $error("response changed while stalled");

   a_bad_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_escape |-> rsp_out_last)
      else $error("bad_escape on a response that is not the last");

   a_mid_has_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> rsp_out_valid)
      else $error("non-final response without a character");

   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_valid && rsp_out_byte != 8'd0) ||
                    (!rsp_out_valid && rsp_out_byte == 8'd0))
      else $error("character byte does not match its valid flag");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response present right after reset");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_out_valid  (rsp_out_valid),
   .rsp_out_last   (rsp_out_last),
   .rsp_bad_escape (rsp_bad_escape)
);
`default_nettype wire
